### rtl/core/smv_pkg.sv
// Shared widths, constants and structures for the sample mean and variance unit.
// Used by every module under rtl/core; depends on nothing else.
package smv_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS = 8;
	localparam int MAX_COUNT = 1048576;

	localparam int COUNT_W = $clog2(MAX_COUNT + 1);
	localparam int SUM_W = SAMPLE_BITS + COUNT_W;
	localparam int ABS_W = SUM_W - 1;
	localparam int SQR_W = 2 * SAMPLE_BITS - 1;
	localparam int SQ_W = 2 * SAMPLE_BITS + COUNT_W - 2;
	localparam int PROD_W = (SQ_W + COUNT_W > 2 * ABS_W) ? SQ_W + COUNT_W : 2 * ABS_W;
	localparam int DVS_W = 2 * COUNT_W;
	localparam int DVD_W = PROD_W + FRAC_BITS;
	localparam int MDIV_STEPS = ABS_W + FRAC_BITS;
	localparam int ITER_W = $clog2(DVD_W + 1);
	localparam int ALU_W = PROD_W;

	localparam int MEAN_W = 24;
	localparam int VAR_W = 39;
	localparam int S_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int M_FIELDS_W = MEAN_W + VAR_W + COUNT_W;
	localparam int M_TDATA_W = ((M_FIELDS_W + 7) / 8) * 8;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [SQ_W-1:0]         sumsq;
		logic [COUNT_W-1:0]      count;
		logic                    overflow;
	} acc_totals_t;

	typedef struct packed {
		logic [MEAN_W-1:0]  mean_q8;
		logic [VAR_W-1:0]   variance_q8;
		logic [COUNT_W-1:0] sample_count;
		logic               too_long;
	} smv_result_t;

	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic             sub;
		logic             cin;
	} alu_req_t;

endpackage

### rtl/core/smv_alu.sv
// Shared adder/subtractor used by the result sequencer for every arithmetic step.
// Depends on smv_pkg.
module smv_alu (
	input  smv_pkg::alu_req_t           req,
	output logic [smv_pkg::ALU_W-1:0]   res,
	output logic                        cout
);

	localparam int W = smv_pkg::ALU_W;

	logic [W:0] full;
	logic [W-1:0] b_eff;

	assign b_eff = req.sub ? ~req.b : req.b;
	assign full = {1'b0, req.a} + {1'b0, b_eff} + {{W{1'b0}}, req.cin};
	assign res = full[W-1:0];
	assign cout = full[W];

endmodule

### rtl/core/smv_accum.sv
// Running sum, sum of squares and sample count for one block of samples.
// Depends on smv_pkg; hands its totals to the result sequencer after the last sample.
module smv_accum (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    take,
	input  logic signed [smv_pkg::SAMPLE_BITS-1:0]  sample,
	input  logic                                    last,
	output logic                                    idle,
	output logic                                    hand,
	output smv_pkg::acc_totals_t                    totals
);

	localparam int SB = smv_pkg::SAMPLE_BITS;
	localparam int SUM_W = smv_pkg::SUM_W;
	localparam int SQ_W = smv_pkg::SQ_W;
	localparam int SQR_W = smv_pkg::SQR_W;
	localparam int COUNT_W = smv_pkg::COUNT_W;

	typedef enum logic [1:0] {A_IDLE, A_ADD, A_HAND} acc_state_t;

	acc_state_t                state_q;
	logic signed [SB-1:0]      x_q;
	logic [SQR_W-1:0]          sq_q;
	logic                      last_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic [SQ_W-1:0]           sumsq_q;
	logic [COUNT_W-1:0]        count_q;
	logic                      ovf_q;
	logic signed [2*SB-1:0]    sq_full;

	assign sq_full = sample * sample;

	always_ff @(posedge clk) begin
		if (take) begin
			x_q <= sample;
			sq_q <= sq_full[SQR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			last_q <= 1'b0;
			sum_q <= '0;
			sumsq_q <= '0;
			count_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			case (state_q)
				A_IDLE: begin
					if (take) begin
						last_q <= last;
						state_q <= A_ADD;
					end
				end
				A_ADD: begin
					if (count_q == COUNT_W'(smv_pkg::MAX_COUNT)) begin
						ovf_q <= 1'b1;
					end else begin
						sum_q <= sum_q + SUM_W'(x_q);
						sumsq_q <= sumsq_q + SQ_W'(sq_q);
						count_q <= count_q + 1'b1;
					end
					state_q <= last_q ? A_HAND : A_IDLE;
				end
				A_HAND: begin
					sum_q <= '0;
					sumsq_q <= '0;
					count_q <= '0;
					ovf_q <= 1'b0;
					state_q <= A_IDLE;
				end
				default: begin
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	assign idle = (state_q == A_IDLE);
	assign hand = (state_q == A_HAND);
	assign totals.sum = sum_q;
	assign totals.sumsq = sumsq_q;
	assign totals.count = count_q;
	assign totals.overflow = ovf_q;

endmodule

### rtl/core/smv_calc.sv
// Sequencer that turns block totals into mean and unbiased variance.
// Depends on smv_pkg; drives the shared smv_alu for shift-add multiplies and restoring divides.
module smv_calc (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  smv_pkg::acc_totals_t            totals,
	output logic                            busy,
	output smv_pkg::alu_req_t               alu_req,
	input  logic [smv_pkg::ALU_W-1:0]       alu_res,
	input  logic                            alu_cout,
	output logic                            res_valid,
	input  logic                            res_ready,
	output smv_pkg::smv_result_t            result
);

	localparam int COUNT_W = smv_pkg::COUNT_W;
	localparam int ABS_W = smv_pkg::ABS_W;
	localparam int SQ_W = smv_pkg::SQ_W;
	localparam int PROD_W = smv_pkg::PROD_W;
	localparam int DVS_W = smv_pkg::DVS_W;
	localparam int DVD_W = smv_pkg::DVD_W;
	localparam int ITER_W = smv_pkg::ITER_W;
	localparam int ALU_W = smv_pkg::ALU_W;
	localparam int FRAC_BITS = smv_pkg::FRAC_BITS;
	localparam int MEAN_W = smv_pkg::MEAN_W;
	localparam int VAR_W = smv_pkg::VAR_W;
	localparam int MDIV_STEPS = smv_pkg::MDIV_STEPS;

	typedef enum logic [3:0] {
		C_IDLE, C_ABS, C_MDIV, C_MFIX, C_NSQ, C_SQ, C_SUB, C_NM1, C_NN, C_VDIV, C_DONE
	} calc_state_t;

	calc_state_t          state_q;
	logic [COUNT_W-1:0]   n_q;
	logic                 ovf_q;
	logic                 neg_q;
	logic [SQ_W-1:0]      sumsq_q;
	logic [ABS_W-1:0]     abs_q;
	logic [PROD_W-1:0]    p_q;
	logic [PROD_W-1:0]    mcand_q;
	logic [ABS_W-1:0]     mplier_q;
	logic [DVD_W-1:0]     dvd_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [ITER_W-1:0]    iter_q;
	logic [MEAN_W-1:0]    mean_q;
	logic [PROD_W-1:0]    p_next;
	logic [DVS_W-1:0]     rem_next;
	logic                 last_iter;

	assign p_next = mplier_q[0] ? alu_res[PROD_W-1:0] : p_q;
	assign rem_next = alu_cout ? alu_res[DVS_W-1:0] : {rem_q[DVS_W-2:0], dvd_q[DVD_W-1]};
	assign last_iter = (iter_q == ITER_W'(1));

	always_comb begin
		alu_req.a = p_q;
		alu_req.b = mcand_q;
		alu_req.sub = 1'b0;
		alu_req.cin = 1'b0;
		case (state_q)
			C_ABS: begin
				alu_req.a = '0;
				alu_req.b = p_q;
				alu_req.sub = p_q[PROD_W-1];
				alu_req.cin = p_q[PROD_W-1];
			end
			C_MDIV, C_VDIV: begin
				alu_req.a = ALU_W'({rem_q, dvd_q[DVD_W-1]});
				alu_req.b = ALU_W'(dvs_q);
				alu_req.sub = 1'b1;
				alu_req.cin = 1'b1;
			end
			C_MFIX: begin
				alu_req.a = '0;
				alu_req.b = ALU_W'(dvd_q[MDIV_STEPS-1:0]);
				alu_req.sub = neg_q;
				alu_req.cin = neg_q & (rem_q == '0);
			end
			C_SUB: begin
				alu_req.a = dvd_q[PROD_W-1:0];
				alu_req.b = p_q;
				alu_req.sub = 1'b1;
				alu_req.cin = 1'b1;
			end
			C_NM1: begin
				alu_req.a = ALU_W'(n_q);
				alu_req.b = '0;
				alu_req.sub = 1'b1;
				alu_req.cin = 1'b0;
			end
			default: begin
				alu_req.a = p_q;
				alu_req.b = mcand_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				if (start) begin
					n_q <= totals.count;
					ovf_q <= totals.overflow;
					sumsq_q <= totals.sumsq;
					p_q <= PROD_W'(totals.sum);
				end
			end
			C_ABS: begin
				abs_q <= alu_res[ABS_W-1:0];
				neg_q <= p_q[PROD_W-1];
				dvd_q <= {alu_res[ABS_W-1:0], {(DVD_W-ABS_W){1'b0}}};
				rem_q <= '0;
				dvs_q <= DVS_W'(n_q);
				iter_q <= ITER_W'(MDIV_STEPS);
			end
			C_MDIV, C_VDIV: begin
				rem_q <= rem_next;
				dvd_q <= {dvd_q[DVD_W-2:0], alu_cout};
				iter_q <= iter_q - 1'b1;
			end
			C_MFIX: begin
				mean_q <= alu_res[MEAN_W-1:0];
				dvd_q <= '0;
				p_q <= '0;
				mcand_q <= PROD_W'(sumsq_q);
				mplier_q <= ABS_W'(n_q);
				iter_q <= ITER_W'(COUNT_W);
			end
			C_NSQ: begin
				mcand_q <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
				iter_q <= iter_q - 1'b1;
				if (last_iter) begin
					dvd_q <= DVD_W'(p_next);
					p_q <= '0;
					mcand_q <= PROD_W'(abs_q);
					mplier_q <= abs_q;
					iter_q <= ITER_W'(ABS_W);
				end else begin
					p_q <= p_next;
				end
			end
			C_SQ: begin
				p_q <= p_next;
				mcand_q <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
				iter_q <= iter_q - 1'b1;
			end
			C_SUB: begin
				dvd_q <= {alu_res[PROD_W-1:0], {FRAC_BITS{1'b0}}};
			end
			C_NM1: begin
				mplier_q <= ABS_W'(alu_res[COUNT_W-1:0]);
				mcand_q <= PROD_W'(n_q);
				p_q <= '0;
				iter_q <= ITER_W'(COUNT_W);
			end
			C_NN: begin
				p_q <= p_next;
				mcand_q <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
				iter_q <= iter_q - 1'b1;
				if (last_iter) begin
					dvs_q <= p_next[DVS_W-1:0];
					rem_q <= '0;
					iter_q <= ITER_W'(DVD_W);
				end
			end
			default: begin
				p_q <= p_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			case (state_q)
				C_IDLE: begin
					if (start) begin
						state_q <= C_ABS;
					end
				end
				C_ABS: state_q <= C_MDIV;
				C_MDIV: begin
					if (last_iter) begin
						state_q <= C_MFIX;
					end
				end
				C_MFIX: state_q <= (n_q < COUNT_W'(2)) ? C_DONE : C_NSQ;
				C_NSQ: begin
					if (last_iter) begin
						state_q <= C_SQ;
					end
				end
				C_SQ: begin
					if (last_iter) begin
						state_q <= C_SUB;
					end
				end
				C_SUB: state_q <= C_NM1;
				C_NM1: state_q <= C_NN;
				C_NN: begin
					if (last_iter) begin
						state_q <= C_VDIV;
					end
				end
				C_VDIV: begin
					if (last_iter) begin
						state_q <= C_DONE;
					end
				end
				C_DONE: begin
					if (res_ready) begin
						state_q <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign busy = (state_q != C_IDLE);
	assign res_valid = (state_q == C_DONE);
	assign result.mean_q8 = mean_q;
	assign result.variance_q8 = dvd_q[VAR_W-1:0];
	assign result.sample_count = n_q;
	assign result.too_long = ovf_q;

endmodule

### rtl/core/sample_mean_variance_unit.sv
// Top level of the sample mean and unbiased variance unit.
// Depends on smv_pkg, smv_accum, smv_calc and smv_alu.
//
// Samples arrive one per transaction on the s_ channel; s_tlast marks the last
// sample of a block. s_tready drops after every accepted transaction while the sample
// is added to the running sums. Samples beyond the count limit are not accumulated
// and only set the too-long flag. After the last sample the totals move to a
// sequencer that runs every multiply and divide one bit per cycle through a single
// shared adder. The result transaction then appears on the m_ channel; s_tready
// stays low until the sequencer has handed the result to the output register.
// The result sits in an output register, so the next block may start while it waits;
// if the receiver stalls, the sequencer holds a finished result until the output
// register frees, and only then takes new samples again.
// Reset clears the running sums, the sequencer state and the output valid flag; no
// clearing pass is needed and the block is ready in the first cycle after reset.
module sample_mean_variance_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [smv_pkg::S_TDATA_W-1:0]       s_tdata,   // [15:0] sample
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [smv_pkg::M_TDATA_W-1:0]       m_tdata,   // mean_q8, variance_q8, sample_count
	output logic                                m_tuser    // too_long
);

	localparam int SB = smv_pkg::SAMPLE_BITS;
	localparam int ALU_W = smv_pkg::ALU_W;
	localparam int COUNT_W = smv_pkg::COUNT_W;
	localparam int PAD_W = smv_pkg::M_TDATA_W - smv_pkg::M_FIELDS_W;

	logic                     take;
	logic                     acc_idle;
	logic                     acc_hand;
	smv_pkg::acc_totals_t     totals;
	logic                     calc_busy;
	smv_pkg::alu_req_t        alu_req;
	logic [ALU_W-1:0]         alu_res;
	logic                     alu_cout;
	logic                     res_valid;
	logic                     res_ready;
	smv_pkg::smv_result_t     result;
	logic                     out_valid_q;
	smv_pkg::smv_result_t     out_q;

	assign s_tready = acc_idle && !calc_busy;
	assign take = s_tvalid && s_tready;

	smv_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.sample (s_tdata[SB-1:0]),
		.last   (s_tlast),
		.idle   (acc_idle),
		.hand   (acc_hand),
		.totals (totals)
	);

	smv_calc u_calc (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (acc_hand),
		.totals    (totals),
		.busy      (calc_busy),
		.alu_req   (alu_req),
		.alu_res   (alu_res),
		.alu_cout  (alu_cout),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.result    (result)
	);

	smv_alu u_alu (
		.req  (alu_req),
		.res  (alu_res),
		.cout (alu_cout)
	);

	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {{PAD_W{1'b0}}, out_q.sample_count, out_q.variance_q8, out_q.mean_q8};
	assign m_tuser = out_q.too_long;

	ap_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> !s_tready)
		else $error("Input accepted in two consecutive cycles.");

	ap_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		acc_hand |-> !calc_busy)
		else $error("Block totals handed over while the sequencer is busy.");

	ap_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_q.sample_count != '0 &&
			out_q.sample_count <= COUNT_W'(smv_pkg::MAX_COUNT)))
		else $error("Reported sample count out of range.");

	ap_too_long_full: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> out_q.sample_count == COUNT_W'(smv_pkg::MAX_COUNT))
		else $error("Too-long flag set on a block below the count limit.");

endmodule
